// ===== src/gif_lzw_pixel_decoder_assert.svh =====
// Assertion macros for the GIF LZW pixel decoder.
// No dependencies; taken in by files that carry concurrent checks.
`ifndef GIF_LZW_PIXEL_DECODER_ASSERT_SVH
`define GIF_LZW_PIXEL_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define GLD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("check failed");
`define GLD_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("bad state");
`else
`define GLD_ASSERT(lbl, clk, rst_n, prop)
`define GLD_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== src/gld_pkg.sv =====
// Shared types and constants for the GIF LZW pixel decoder.
// No dependencies.
package gld_pkg;
	localparam int STK_DEPTH = 4096;
	localparam int STK_AW    = 12;
	localparam int CNT_W     = 13;

	localparam logic [1:0] ACT_PUSH   = 2'd0;
	localparam logic [1:0] ACT_PULL   = 2'd1;
	localparam logic [1:0] ACT_START  = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam logic [2:0] ST_ACCEPTED = 3'd0;
	localparam logic [2:0] ST_BUSY     = 3'd1;
	localparam logic [2:0] ST_PIXEL    = 3'd2;
	localparam logic [2:0] ST_CLEAR    = 3'd3;
	localparam logic [2:0] ST_NEED     = 3'd4;
	localparam logic [2:0] ST_ENDED    = 3'd5;
	localparam logic [2:0] ST_BAD      = 3'd6;

	localparam logic [3:0] MIN_RESET = 4'd8;

	typedef enum logic [2:0] {
		FSM_IDLE = 3'b001,
		FSM_POP  = 3'b010,
		FSM_WALK = 3'b100
	} fsm_t;

	// minimum code size clamped to 2..8
	function automatic logic [3:0] eff_min(input logic [3:0] m);
		logic [3:0] r;
		r = m;
		if (m < 4'd2) r = 4'd2;
		if (m > 4'd8) r = 4'd8;
		return r;
	endfunction
endpackage

// ===== src/gld_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module gld_ram #(
	parameter int W  = 8,
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [(1<<AW)];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== src/gif_lzw_pixel_decoder.sv =====
// GIF LZW pixel decoder. One result beat per input beat, one beat in flight.
// Simple beats give a registered result; a pull from the stack reads the stack
// RAM, then hands out the byte from FSM_POP; decode of a code walks the dictionary
// entry by entry (dictionary RAM port); for a code equal to the next free one its own new entry is not walked.
// A new beat is taken only after the result of the last one has been handed off.
// arst_n clears all control state; RAM contents are undefined until written.
module gif_lzw_pixel_decoder
	import gld_pkg::*;
#(
	parameter int MAX_CODE_BITS = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic [1:0] s_tuser,   // [1:0] action
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] pixel_index
	output logic [2:0] m_tuser,   // [2:0] status
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata
);
	`include "gif_lzw_pixel_decoder_assert.svh"

	localparam int MB    = MAX_CODE_BITS;
	localparam int NFC_W = MB + 1;
	localparam int BUF_W = MB + 8;
	localparam int DW    = MB + 8;   // dictionary word: {prefix, suffix}

	fsm_t              state_q;
	logic              ovalid_q;
	logic [2:0]        ostatus_q;
	logic [7:0]        opix_q;
	logic [3:0]        min_q;
	logic [BUF_W-1:0]  buf_q;
	logic [4:0]        held_q;
	logic [3:0]        cw_q;
	logic [NFC_W-1:0]  nfc_q;
	logic [MB-1:0]     prev_q;
	logic [7:0]        prev_first_q;   // first symbol of the previous code's string
	logic              after_clear_q;
	logic              fin_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              pend_q;         // dictionary write deferred to end of walk
	logic [MB-1:0]     pend_addr_q;
	logic [MB-1:0]     pend_prefix_q;

	// clear and end-of-information codes, and the initial next free code, for the active and the written minimum size
	logic [3:0]       emin, cfg_emin;
	logic [MB-1:0]    clr, eoi;
	logic [NFC_W-1:0] nfc_init, cfg_nfc_init;
	always_comb begin
		emin         = eff_min(min_q);
		cfg_emin     = eff_min(cfg_wdata);
		clr          = MB'(1) << emin;
		eoi          = clr + MB'(1);
		nfc_init     = (NFC_W'(1) << emin) + NFC_W'(2);
		cfg_nfc_init = (NFC_W'(1) << cfg_emin) + NFC_W'(2);
	end

	// code extraction, LSB first
	logic             accept;
	logic [1:0]       action;
	logic [BUF_W-1:0] mask;
	logic [MB-1:0]    code;
	logic             have_code, stk_empty, stk_room, tbl_room;
	logic [NFC_W-1:0] nfc_inc;
	logic             grow;
	always_comb begin
		accept    = s_tvalid && s_tready;
		action    = s_tuser;
		mask      = (BUF_W'(1) << cw_q) - BUF_W'(1);
		code      = MB'(buf_q & mask);
		have_code = held_q >= {1'b0, cw_q};
		stk_empty = (cnt_q == '0);
		stk_room  = !cnt_q[CNT_W-1];
		tbl_room  = !nfc_q[NFC_W-1];
		nfc_inc   = nfc_q + NFC_W'(1);
		grow      = (nfc_inc == (NFC_W'(1) << cw_q)) && (cw_q < 4'(MB));
	end

	// classification of a decode on a pull
	logic pull_dec, is_clr, is_eoi, is_root, is_new, is_bad;
	logic decode_ok, root_c, new_c, mid_c, prev_walk;
	always_comb begin
		pull_dec  = accept && action == ACT_PULL && stk_empty && !fin_q && have_code;
		is_clr    = code == clr;
		is_eoi    = code == eoi;
		is_root   = code < clr;
		is_new    = {1'b0, code} == nfc_q;
		is_bad    = {1'b0, code} > nfc_q;
		decode_ok = pull_dec && !is_clr && !is_eoi && !after_clear_q && !is_bad;
		root_c    = decode_ok && is_root;
		new_c     = decode_ok && is_new;
		mid_c     = decode_ok && !is_root && !is_new;
		prev_walk = prev_q > eoi;
	end

	// result of an accepted beat: held back for a stack read or a chain walk
	logic       out_wait;
	logic [7:0] out_pix;
	always_comb begin
		out_wait = action == ACT_PULL && (!stk_empty || mid_c || (new_c && prev_walk));
		out_pix  = 8'd0;
		if (pull_dec && is_root) begin
			out_pix = code[7:0];
		end else if (new_c && !prev_walk) begin
			out_pix = prev_q[7:0];
		end
	end

	// dictionary RAM
	logic          d_we, d_re;
	logic [MB-1:0] d_waddr, d_raddr;
	logic [DW-1:0] d_wdata, d_rdata;
	logic [MB-1:0] d_prefix;
	logic [7:0]    d_suffix;
	logic          in_walk, walk_more, walk_end;
	assign d_prefix = d_rdata[DW-1:8];
	assign d_suffix = d_rdata[7:0];
	assign in_walk  = state_q == FSM_WALK;
	assign walk_more = in_walk && (d_prefix > eoi);
	assign walk_end  = in_walk && !walk_more;

	always_comb begin
		d_we    = ((root_c || new_c) && tbl_room) || (walk_end && pend_q);
		d_waddr = in_walk ? pend_addr_q : nfc_q[MB-1:0];
		if (in_walk) begin
			d_wdata = {pend_prefix_q, d_prefix[7:0]};
		end else begin
			d_wdata = {prev_q, root_c ? code[7:0] : prev_first_q};
		end
		// KwKwK: the new entry is forwarded, the walk starts at the previous code
		d_re    = walk_more || mid_c || (new_c && prev_walk);
		if (walk_more) begin
			d_raddr = d_prefix;
		end else if (mid_c) begin
			d_raddr = code;
		end else begin
			d_raddr = prev_q;
		end
	end

	gld_ram #(.W(DW), .AW(MB)) u_dict (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.re(d_re), .raddr(d_raddr), .rdata(d_rdata)
	);

	// pixel stack RAM
	logic              s_we, s_re;
	logic [STK_AW-1:0] s_waddr, s_raddr;
	logic [7:0]        s_wdata, s_rdata;
	logic              push;
	always_comb begin
		push    = new_c || in_walk;
		s_we    = push && stk_room;
		s_waddr = cnt_q[STK_AW-1:0];
		s_wdata = new_c ? prev_first_q : d_suffix;
		s_re    = accept && action == ACT_PULL && !stk_empty;
		s_raddr = STK_AW'(cnt_q - CNT_W'(1));
	end

	gld_ram #(.W(8), .AW(STK_AW)) u_stack (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.re(s_re), .raddr(s_raddr), .rdata(s_rdata)
	);

	assign s_tready = (state_q == FSM_IDLE) && !ovalid_q;
	assign m_tvalid = ovalid_q;
	assign m_tdata  = opix_q;
	assign m_tuser  = ostatus_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= FSM_IDLE;
			ovalid_q      <= 1'b0;
			ostatus_q     <= ST_ACCEPTED;
			opix_q        <= '0;
			min_q         <= MIN_RESET;
			buf_q         <= '0;
			held_q        <= '0;
			cw_q          <= 4'd9;
			nfc_q         <= NFC_W'(258);
			prev_q        <= '0;
			prev_first_q  <= '0;
			after_clear_q <= 1'b1;
			fin_q         <= 1'b0;
			cnt_q         <= '0;
			pend_q        <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				ovalid_q <= 1'b0;
			end
			if (push && stk_room) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cfg_we) begin
				// register write restarts decoding with the new size
				min_q         <= cfg_wdata;
				cnt_q         <= '0;
				buf_q         <= '0;
				held_q        <= '0;
				prev_q        <= '0;
				fin_q         <= 1'b0;
				cw_q          <= cfg_emin + 4'd1;
				nfc_q         <= cfg_nfc_init;
				after_clear_q <= 1'b1;
			end else if (accept) begin
				ovalid_q <= !out_wait;
				opix_q   <= out_pix;
				case (action)
					ACT_START: begin
						cnt_q         <= '0;
						buf_q         <= '0;
						held_q        <= '0;
						prev_q        <= '0;
						fin_q         <= 1'b0;
						cw_q          <= emin + 4'd1;
						nfc_q         <= nfc_init;
						after_clear_q <= 1'b1;
						ostatus_q     <= ST_ACCEPTED;
					end
					ACT_PUSH: begin
						if (fin_q) begin
							ostatus_q <= ST_ENDED;
						end else if (!stk_empty || have_code) begin
							ostatus_q <= ST_BUSY;
						end else begin
							buf_q     <= buf_q | (BUF_W'(s_tdata) << held_q);
							held_q    <= held_q + 5'd8;
							ostatus_q <= ST_ACCEPTED;
						end
					end
					ACT_PULL: begin
						if (!stk_empty) begin
							// top of stack is read into the stack RAM's read register now, then handed out from FSM_POP
							cnt_q    <= cnt_q - CNT_W'(1);
							state_q  <= FSM_POP;
						end else if (fin_q) begin
							ostatus_q <= ST_ENDED;
						end else if (!have_code) begin
							ostatus_q <= ST_NEED;
						end else begin
							buf_q  <= buf_q >> cw_q;
							held_q <= held_q - 5'(cw_q);
							if (is_clr) begin
								cw_q          <= emin + 4'd1;
								nfc_q         <= nfc_init;
								after_clear_q <= 1'b1;
								ostatus_q     <= ST_CLEAR;
							end else if (is_eoi) begin
								fin_q     <= 1'b1;
								ostatus_q <= ST_ENDED;
							end else if (after_clear_q) begin
								if (is_root) begin
									prev_q        <= code;
									prev_first_q  <= code[7:0];
									after_clear_q <= 1'b0;
									ostatus_q     <= ST_PIXEL;
								end else begin
									ostatus_q <= ST_BAD;
								end
							end else if (is_bad) begin
								ostatus_q <= ST_BAD;
							end else begin
								if (tbl_room) begin
									nfc_q <= nfc_inc;
									if (grow) begin
										cw_q <= cw_q + 4'd1;
									end
								end
								prev_q    <= code;
								ostatus_q <= ST_PIXEL;
								if (root_c) begin
									prev_first_q <= code[7:0];
								end else if (out_wait) begin
									// chain walk through the dictionary
									state_q       <= FSM_WALK;
									pend_q        <= mid_c && tbl_room;
									pend_addr_q   <= nfc_q[MB-1:0];
									pend_prefix_q <= prev_q;
								end
							end
						end
					end
					default: begin
						ostatus_q <= ST_BUSY;
					end
				endcase
			end else begin
				case (state_q)
					FSM_POP: begin
						ovalid_q  <= 1'b1;
						ostatus_q <= ST_PIXEL;
						opix_q    <= s_rdata;
						state_q   <= FSM_IDLE;
					end
					FSM_WALK: begin
						if (!walk_more) begin
							// prefix is the root: it is the pixel handed out
							ovalid_q     <= 1'b1;
							ostatus_q    <= ST_PIXEL;
							opix_q       <= d_prefix[7:0];
							prev_first_q <= d_prefix[7:0];
							pend_q       <= 1'b0;
							state_q      <= FSM_IDLE;
						end
					end
					default: begin
						state_q <= FSM_IDLE;
					end
				endcase
			end
		end
	end

	`GLD_NEVER(a_cw_cap, clk, arst_n, cw_q > 4'(MB))
	`GLD_NEVER(a_cnt_cap, clk, arst_n, cnt_q > CNT_W'(STK_DEPTH))
	`GLD_ASSERT(a_walk_done, clk, arst_n, walk_end |=> ovalid_q && state_q == FSM_IDLE)
	`GLD_ASSERT(a_pop_out, clk, arst_n, state_q == FSM_POP |=> ovalid_q && ostatus_q == ST_PIXEL)
endmodule
